// File: design/acrr_pkg.sv
// acrr_pkg: shared widths, result codes and the window arithmetic of the
// cumulative-ACK reorder receiver. No dependencies.

package acrr_pkg;

  localparam int SEQ_W = 32;
  localparam int TAG_W = 32;
  localparam int WIN_W = 16;

  localparam logic KIND_DELIVER = 1'b0;
  localparam logic KIND_ACK     = 1'b1;

  localparam logic [WIN_W-1:0] ADV_WINDOW_RESET = 16'd16;

  // Advertised window minus buffered count, floored at zero.
  function automatic logic [WIN_W-1:0] win_left(input logic [WIN_W-1:0] adv,
                                                input logic [WIN_W-1:0] cnt);
    return (adv > cnt) ? (adv - cnt) : '0;
  endfunction

endpackage

// File: design/acrr_ram.sv
// acrr_ram: generic single-write, single-read RAM with a registered read port.
// Depends on nothing.

module acrr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/cumulative_ack_reorder_receiver.sv
// cumulative_ack_reorder_receiver: top level, control sequencer, occupancy bits
// and result registers. Uses acrr_pkg and one acrr_ram for the buffered tags.
//
// Usage:
//   Input: present a segment (in_seq_num, in_payload_tag) with start high; it
//   is taken at the rising edge where start is high and busy is low.
//   Results: each result sits on the out_ ports for exactly one cycle with
//   out_strobe high. The receiver cannot stall, so nothing is held back.
//   Config: cfg_wr_en writes cfg_wr_data into the advertised window at once.
// Timing and throughput:
//   A segment ahead of the expected number (buffered or overflowed) gives its
//   ACK in the cycle after acceptance; busy stays low, so one segment a cycle.
//   An old segment gives no result.
//   An in-order segment with k buffered successors gives its delivery in the cycle
//   after acceptance, then one delivery a cycle, then the ACK; busy stays high until
//   the drain loop, which reads one tag a cycle from the RAM, finds an empty slot.
// Reset (rst_n low, synchronous): expected number and head slot return to zero,
//   all slots are marked empty, the advertised window returns to 16. The tag
//   RAM is not cleared; an entry is read only after it has been written.

module cumulative_ack_reorder_receiver #(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [acrr_pkg::SEQ_W-1:0] in_seq_num,
  input  logic [acrr_pkg::TAG_W-1:0] in_payload_tag,
  input  logic                       cfg_wr_en,
  input  logic [acrr_pkg::WIN_W-1:0] cfg_wr_data,
  output logic                       out_strobe,
  output logic                       out_kind,
  output logic [acrr_pkg::SEQ_W-1:0] out_deliver_seq,
  output logic [acrr_pkg::TAG_W-1:0] out_deliver_tag,
  output logic [acrr_pkg::SEQ_W-1:0] out_ack_num,
  output logic [acrr_pkg::WIN_W-1:0] out_window_left,
  output logic                       out_overflow,
  output logic                       out_last
);

  localparam int IDX_W = $clog2(WINDOW_DEPTH);
  localparam int CNT_W = $clog2(WINDOW_DEPTH);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic                       state_r, state_nxt;
  logic [acrr_pkg::SEQ_W-1:0] exp_r, exp_nxt;
  logic [IDX_W-1:0]           head_r, head_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [WINDOW_DEPTH-1:0]    present_r, present_nxt;
  logic [acrr_pkg::WIN_W-1:0] adv_r;

  logic                       strobe_r, strobe_nxt;
  logic                       kind_r, kind_nxt;
  logic [acrr_pkg::SEQ_W-1:0] dseq_r, dseq_nxt;
  logic [acrr_pkg::TAG_W-1:0] dtag_r, dtag_nxt;
  logic                       tag_sel_r, tag_sel_nxt;
  logic [acrr_pkg::SEQ_W-1:0] ack_r, ack_nxt;
  logic [acrr_pkg::WIN_W-1:0] win_r, win_nxt;
  logic                       ovf_r, ovf_nxt;
  logic                       last_r, last_nxt;

  logic                       accept;
  logic [acrr_pkg::SEQ_W-1:0] seq_gap;
  logic                       is_old;
  logic                       is_over;
  logic [IDX_W:0]             slot_sum;
  logic [IDX_W-1:0]           slot;
  logic [IDX_W-1:0]           head_inc;

  logic                       ram_wr_en;
  logic                       ram_rd_en;
  logic [acrr_pkg::TAG_W-1:0] ram_rd_data;

  assign busy   = (state_r == ST_DRAIN);
  assign accept = start && !busy;

  assign seq_gap = in_seq_num - exp_r;
  assign is_old  = seq_gap[acrr_pkg::SEQ_W-1];
  assign is_over = !is_old && (seq_gap >= acrr_pkg::SEQ_W'(WINDOW_DEPTH));

  // Slot of an ahead segment: head plus distance, wrapped once.
  assign slot_sum = {1'b0, head_r} + seq_gap[IDX_W:0];
  assign slot = (slot_sum >= (IDX_W+1)'(WINDOW_DEPTH)) ?
                IDX_W'(slot_sum - (IDX_W+1)'(WINDOW_DEPTH)) : slot_sum[IDX_W-1:0];

  assign head_inc = (head_r == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : head_r + 1'b1;

  always_comb begin
    state_nxt   = state_r;
    exp_nxt     = exp_r;
    head_nxt    = head_r;
    cnt_nxt     = cnt_r;
    present_nxt = present_r;
    strobe_nxt  = 1'b0;
    kind_nxt    = kind_r;
    dseq_nxt    = dseq_r;
    dtag_nxt    = dtag_r;
    tag_sel_nxt = tag_sel_r;
    ack_nxt     = ack_r;
    win_nxt     = win_r;
    ovf_nxt     = ovf_r;
    last_nxt    = last_r;
    ram_wr_en   = 1'b0;
    ram_rd_en   = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept && (seq_gap == '0)) begin
          // In order: deliver now, then drain successors.
          strobe_nxt  = 1'b1;
          kind_nxt    = acrr_pkg::KIND_DELIVER;
          dseq_nxt    = in_seq_num;
          dtag_nxt    = in_payload_tag;
          tag_sel_nxt = 1'b0;
          ack_nxt     = '0;
          win_nxt     = '0;
          ovf_nxt     = 1'b0;
          last_nxt    = 1'b0;
          exp_nxt     = exp_r + 1'b1;
          head_nxt    = head_inc;
          state_nxt   = ST_DRAIN;
        end else if (accept && !is_old) begin
          strobe_nxt  = 1'b1;
          kind_nxt    = acrr_pkg::KIND_ACK;
          dseq_nxt    = '0;
          dtag_nxt    = '0;
          tag_sel_nxt = 1'b0;
          ack_nxt     = exp_r;
          ovf_nxt     = is_over;
          last_nxt    = 1'b1;
          if (!is_over && !present_r[slot]) begin
            // Keep the first copy of a duplicate; store only into an empty slot.
            ram_wr_en          = 1'b1;
            present_nxt[slot]  = 1'b1;
            cnt_nxt            = cnt_r + 1'b1;
          end
          win_nxt = acrr_pkg::win_left(adv_r, acrr_pkg::WIN_W'(cnt_nxt));
        end
      end
      ST_DRAIN: begin
        if (present_r[head_r]) begin
          // Tag arrives from the RAM in the cycle the delivery is shown.
          ram_rd_en           = 1'b1;
          present_nxt[head_r] = 1'b0;
          cnt_nxt             = cnt_r - 1'b1;
          strobe_nxt          = 1'b1;
          kind_nxt            = acrr_pkg::KIND_DELIVER;
          dseq_nxt            = exp_r;
          tag_sel_nxt         = 1'b1;
          ack_nxt             = '0;
          win_nxt             = '0;
          ovf_nxt             = 1'b0;
          last_nxt            = 1'b0;
          exp_nxt             = exp_r + 1'b1;
          head_nxt            = head_inc;
        end else begin
          strobe_nxt  = 1'b1;
          kind_nxt    = acrr_pkg::KIND_ACK;
          dseq_nxt    = '0;
          dtag_nxt    = '0;
          tag_sel_nxt = 1'b0;
          ack_nxt     = exp_r;
          win_nxt     = acrr_pkg::win_left(adv_r, acrr_pkg::WIN_W'(cnt_r));
          ovf_nxt     = 1'b0;
          last_nxt    = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      exp_r     <= '0;
      head_r    <= '0;
      cnt_r     <= '0;
      present_r <= '0;
      strobe_r  <= 1'b0;
      adv_r     <= acrr_pkg::ADV_WINDOW_RESET;
    end else begin
      state_r   <= state_nxt;
      exp_r     <= exp_nxt;
      head_r    <= head_nxt;
      cnt_r     <= cnt_nxt;
      present_r <= present_nxt;
      strobe_r  <= strobe_nxt;
      if (cfg_wr_en) begin
        adv_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    dseq_r    <= dseq_nxt;
    dtag_r    <= dtag_nxt;
    tag_sel_r <= tag_sel_nxt;
    ack_r     <= ack_nxt;
    win_r     <= win_nxt;
    ovf_r     <= ovf_nxt;
    last_r    <= last_nxt;
  end

  acrr_ram #(
    .WIDTH (acrr_pkg::TAG_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_tag_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (slot),
    .wr_data (in_payload_tag),
    .rd_en   (ram_rd_en),
    .rd_addr (head_r),
    .rd_data (ram_rd_data)
  );

  assign out_strobe      = strobe_r;
  assign out_kind        = kind_r;
  assign out_deliver_seq = dseq_r;
  assign out_deliver_tag = tag_sel_r ? ram_rd_data : dtag_r;
  assign out_ack_num     = ack_r;
  assign out_window_left = win_r;
  assign out_overflow    = ovf_r;
  assign out_last        = last_r;

endmodule

// File: design/acrr_checker.sv
// acrr_checker: port-level assertions on the result sequence of the receiver,
// bound to cumulative_ack_reorder_receiver. Uses acrr_pkg.

module acrr_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       busy,
  input logic                       out_strobe,
  input logic                       out_kind,
  input logic [acrr_pkg::SEQ_W-1:0] out_deliver_seq,
  input logic [acrr_pkg::SEQ_W-1:0] out_ack_num,
  input logic                       out_last
);

  // A run that has not ended carries on in the very next cycle.
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |=> out_strobe)
    else $error("result run broken before its final transaction");

  // While draining, a delivery is on the result ports every cycle.
  a_busy_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> out_strobe && (out_kind == acrr_pkg::KIND_DELIVER))
    else $error("busy without a delivery transaction");

  // Back-to-back deliveries carry consecutive sequence numbers.
  a_seq_consecutive: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_kind == acrr_pkg::KIND_DELIVER) &&
    $past(out_strobe && (out_kind == acrr_pkg::KIND_DELIVER))
    |-> out_deliver_seq == $past(out_deliver_seq) + 1'b1)
    else $error("delivered sequence numbers not consecutive");

  // The cumulative ACK points just past the last delivered segment.
  a_ack_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_kind == acrr_pkg::KIND_ACK) &&
    $past(out_strobe && (out_kind == acrr_pkg::KIND_DELIVER))
    |-> out_ack_num == $past(out_deliver_seq) + 1'b1)
    else $error("cumulative ACK does not follow last delivery");

endmodule

bind cumulative_ack_reorder_receiver acrr_checker u_acrr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .busy            (busy),
  .out_strobe      (out_strobe),
  .out_kind        (out_kind),
  .out_deliver_seq (out_deliver_seq),
  .out_ack_num     (out_ack_num),
  .out_last        (out_last)
);
